/* rtl/core/lmts_pkg.sv */
// Shared types, character mapping and font table for the LED matrix scroller.
// Used by lmts_cell and led_matrix_text_scroller; depends on nothing.
`default_nettype none

package lmts_pkg;

   localparam int unsigned COLUMNS     = 8;
   localparam int unsigned GLYPH_COUNT = 27;

   localparam logic [7:0] FIRST_CODE = 8'h40;  // '@', blank glyph
   localparam logic [7:0] LAST_CODE  = 8'h5A;  // 'Z'
   localparam logic [7:0] LOWER_A    = 8'h61;  // 'a'
   localparam logic [7:0] CASE_GAP   = 8'h20;  // 'a' - 'A'

   localparam logic [2:0] LAST_STEP = 3'd7;

   typedef logic [4:0] glyph_idx_type;
   typedef logic [7:0] column_type;

   // Control word broadcast along the row of cells
   typedef struct packed {
      logic advance;   // produce one frame this cycle
      logic clear;     // frame reads as zero before this step
      logic vertical;  // shift bits up instead of columns left
      logic load;      // take a new glyph column
   } lmts_ctrl_type;

   localparam column_type GLYPH_ROM [GLYPH_COUNT][COLUMNS] = '{
      '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
      '{8'h00,8'h1F,8'h24,8'h44,8'h44,8'h24,8'h1F,8'h00},
      '{8'h00,8'h00,8'h36,8'h49,8'h49,8'h49,8'h7F,8'h00},
      '{8'h00,8'h22,8'h41,8'h41,8'h41,8'h22,8'h1C,8'h00},
      '{8'h00,8'h1C,8'h22,8'h41,8'h41,8'h41,8'h7F,8'h00},
      '{8'h00,8'h00,8'h41,8'h49,8'h49,8'h49,8'h7F,8'h00},
      '{8'h00,8'h00,8'h40,8'h48,8'h48,8'h48,8'h7F,8'h00},
      '{8'h00,8'h27,8'h45,8'h41,8'h41,8'h22,8'h1C,8'h00},
      '{8'h00,8'h7F,8'h08,8'h08,8'h08,8'h08,8'h7F,8'h00},
      '{8'h00,8'h00,8'h00,8'h41,8'h7F,8'h41,8'h00,8'h00},
      '{8'h00,8'h00,8'h00,8'h40,8'h7E,8'h41,8'h02,8'h00},
      '{8'h00,8'h00,8'h41,8'h24,8'h18,8'h10,8'h7F,8'h00},
      '{8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,8'h7F,8'h00},
      '{8'h00,8'h7F,8'h20,8'h10,8'h08,8'h20,8'h7F,8'h00},
      '{8'h00,8'h7F,8'h02,8'h04,8'h08,8'h10,8'h7F,8'h00},
      '{8'h00,8'h1C,8'h22,8'h41,8'h41,8'h22,8'h1C,8'h00},
      '{8'h00,8'h00,8'h30,8'h48,8'h48,8'h48,8'h7F,8'h00},
      '{8'h00,8'h1D,8'h23,8'h41,8'h41,8'h22,8'h1C,8'h00},
      '{8'h00,8'h00,8'h31,8'h4A,8'h4C,8'h48,8'h7F,8'h00},
      '{8'h00,8'h42,8'h45,8'h49,8'h49,8'h29,8'h11,8'h00},
      '{8'h00,8'h00,8'h40,8'h40,8'h7F,8'h40,8'h40,8'h00},
      '{8'h00,8'h7E,8'h01,8'h01,8'h01,8'h01,8'h7E,8'h00},
      '{8'h00,8'h78,8'h04,8'h02,8'h03,8'h04,8'h78,8'h00},
      '{8'h00,8'h7E,8'h01,8'h01,8'h1E,8'h01,8'h7E,8'h00},
      '{8'h00,8'h43,8'h24,8'h18,8'h28,8'h44,8'h43,8'h00},
      '{8'h00,8'h40,8'h20,8'h10,8'h1F,8'h20,8'h40,8'h00},
      '{8'h00,8'h61,8'h51,8'h49,8'h45,8'h42,8'h41,8'h00}
   };

   // Map a character byte to a font entry: blank below '@', fold lower case,
   // blank past 'Z'
   function automatic glyph_idx_type glyph_index(input logic [7:0] code);
      logic [7:0] c;
      c = code;
      if (c < FIRST_CODE) begin
         c = FIRST_CODE;
      end
      if (c >= LOWER_A) begin
         c = c - CASE_GAP;
      end
      if (c > LAST_CODE) begin
         return '0;
      end
      return glyph_idx_type'(c - FIRST_CODE);
   endfunction

   // One column of one glyph; unused entries read blank
   function automatic column_type glyph_column(input glyph_idx_type idx,
                                               input logic [2:0] col);
      if (idx >= glyph_idx_type'(GLYPH_COUNT)) begin
         return '0;
      end
      return GLYPH_ROM[idx][col];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/lmts_cell.sv */
// One frame column of the scroller: column bits and the glyph column it feeds in.
// Depends on lmts_pkg for the control word.
`default_nettype none

module lmts_cell
   import lmts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lmts_ctrl_type ctrl,
   input  column_type    glyph_in,
   input  column_type    left_in,
   output column_type    base_out,
   output column_type    frame_out
);

   column_type col_ff, col_in;
   column_type glyph_ff, glyph_in_next;
   column_type base;

   // Column as seen this step, after an optional clear
   assign base     = ctrl.clear ? '0 : col_ff;
   assign base_out = base;

   // Vertical: shift up and take the glyph MSB; horizontal: take the neighbor
   always_comb begin
      col_in = ctrl.vertical ? {base[6:0], glyph_ff[7]} : left_in;
   end

   // Horizontal emits before the shift, vertical after
   assign frame_out = ctrl.vertical ? col_in : base;

   // Walk glyph bits toward the MSB, reload on a new word
   always_comb begin
      glyph_in_next = glyph_ff;
      if (ctrl.load) begin
         glyph_in_next = glyph_in;
      end else if (ctrl.advance) begin
         glyph_in_next = {glyph_ff[6:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (ctrl.advance) begin
         col_ff <= col_in;
      end
      glyph_ff <= glyph_in_next;
   end

endmodule

`default_nettype wire

/* rtl/core/led_matrix_text_scroller.sv */
// Top level of the 8x8 LED matrix text scroller: handshake control, a row of
// lmts_cell columns and the result register. Depends on lmts_pkg, lmts_cell.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_char_code, req_clear_first
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_column_0..7, rsp_last_frame
//   csr     | in        | csr_valid/csr_ready  | csr_scroll_vertical
//
// Each word yields eight frames, one per cycle while rsp_ready stays high; the
// step counter over the row of cells counts the eight frames.
// The next word is taken in the cycle that produces the eighth frame.
// A low rsp_ready with a valid result holds the result register and freezes the cells.
// Synchronous reset zeroes the frame and empties the result register.
`default_nettype none

module led_matrix_text_scroller
   import lmts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_clear_first,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_column_0,
   output logic [7:0] rsp_column_1,
   output logic [7:0] rsp_column_2,
   output logic [7:0] rsp_column_3,
   output logic [7:0] rsp_column_4,
   output logic [7:0] rsp_column_5,
   output logic [7:0] rsp_column_6,
   output logic [7:0] rsp_column_7,
   output logic       rsp_last_frame,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_scroll_vertical
);

   logic          busy_ff, busy_in;
   logic [2:0]    step_ff, step_in;
   logic          clear_ff;
   glyph_idx_type glyph_idx_ff;
   logic          vertical_ff;
   logic          rsp_valid_ff;
   logic          rsp_last_ff;
   column_type    rsp_col_ff [COLUMNS];

   logic          advance;
   logic          req_accept;
   glyph_idx_type new_idx;
   lmts_ctrl_type ctrl;
   column_type    base_w  [COLUMNS];
   column_type    frame_w [COLUMNS];
   column_type    left_w  [COLUMNS];

   // Produce a frame whenever the result register is free or draining
   assign advance    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !busy_ff || (advance && (step_ff == LAST_STEP));
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign new_idx    = glyph_index(req_char_code);

   assign ctrl.advance  = advance;
   assign ctrl.clear    = clear_ff && (step_ff == '0);
   assign ctrl.vertical = vertical_ff;
   assign ctrl.load     = req_accept;

   // Cell 0 takes glyph column 7-n; the rest take the neighbor's column
   genvar gi;
   generate
      for (gi = 0; gi < COLUMNS; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign left_w[gi] = glyph_column(glyph_idx_ff, ~step_ff);
         end else begin : g_link
            assign left_w[gi] = base_w[gi-1];
         end
         lmts_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .glyph_in  (glyph_column(new_idx, 3'(gi))),
            .left_in   (left_w[gi]),
            .base_out  (base_w[gi]),
            .frame_out (frame_w[gi])
         );
      end
   endgenerate

   // Step through the eight frames, chain straight into the next word
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (advance) begin
         step_in = step_ff + 3'd1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
      if (req_accept) begin
         busy_in = 1'b1;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         vertical_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         if (csr_valid && csr_ready) begin
            vertical_ff <= csr_scroll_vertical;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Latch the word's glyph and clear flag; capture each frame
   always_ff @(posedge clock) begin
      if (req_accept) begin
         glyph_idx_ff <= new_idx;
         clear_ff     <= req_clear_first;
      end
      if (advance) begin
         rsp_col_ff  <= frame_w;
         rsp_last_ff <= (step_ff == LAST_STEP);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_last_frame = rsp_last_ff;
   assign rsp_column_0   = rsp_col_ff[0];
   assign rsp_column_1   = rsp_col_ff[1];
   assign rsp_column_2   = rsp_col_ff[2];
   assign rsp_column_3   = rsp_col_ff[3];
   assign rsp_column_4   = rsp_col_ff[4];
   assign rsp_column_5   = rsp_col_ff[5];
   assign rsp_column_6   = rsp_col_ff[6];
   assign rsp_column_7   = rsp_col_ff[7];

endmodule

`default_nettype wire

/* rtl/core/lmts_checker.sv */
// Port-level checks for led_matrix_text_scroller, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module lmts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_column_0,
   input logic       rsp_last_frame
);

   // Hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column_0))
      else $error("stalled result word dropped or changed");

   // Empty the result register out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled frame that is not the last blocks new words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !rsp_last_frame |-> !req_ready)
      else $error("new word taken mid-character under stall");

   // Frames of one character follow without a gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_frame |=> rsp_valid)
      else $error("gap inside a character's frames");

endmodule

bind led_matrix_text_scroller lmts_checker u_lmts_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_column_0   (rsp_column_0),
   .rsp_last_frame (rsp_last_frame)
);

`default_nettype wire

/* sim/led_matrix_text_scroller_tb.sv */
// Self-checking testbench for led_matrix_text_scroller: a scoreboard class predicts the eight
// frames of every accepted character word and checks each frame the block returns.
// Depends on the block's RTL only (led_matrix_text_scroller and the files below it).
`timescale 1ns / 1ps

module led_matrix_text_scroller_tb;

   localparam logic [7:0] CODE_AT      = 8'h40;  // '@', blank glyph
   localparam logic [7:0] CODE_Z       = 8'h5A;  // 'Z'
   localparam logic [7:0] CODE_LOWER_A = 8'h61;  // 'a'
   localparam logic [7:0] CASE_SHIFT   = 8'h20;  // 'a' - 'A'
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned LONG_HOLD   = 120;
   localparam int unsigned DRAIN_LIMIT = 20000;
   localparam int unsigned TAIL_CYCLES = 16;

   // Corner codes: letters at both ends, blank, lower case, codes just past 'Z' and 'z',
   // high byte values and the code just below '@'
   localparam logic [7:0] EDGE_CODES [13] = '{8'h41, 8'h5A, 8'h40, 8'h00, 8'hFF, 8'h61,
                                              8'h7A, 8'h5B, 8'h60, 8'h7B, 8'h7F, 8'h80,
                                              8'h3F};

   // Expected frames of the scroller, predicted one character word at a time
   class frame_scoreboard;
      typedef struct packed {
         logic [63:0] cols;  // column 0 in the top byte
         logic        last;
      } frame_type;

      logic [7:0] frame [8];
      bit         vertical;
      frame_type  expected_q [$];
      int         mismatches;
      int         frames_checked;
      int         chars_noted;
      int         clears_noted;

      function new();
         foreach (frame[i]) frame[i] = '0;
         vertical       = 1'b0;
         mismatches     = 0;
         frames_checked = 0;
         chars_noted    = 0;
         clears_noted   = 0;
      endfunction

      // Font: eight columns per glyph, column 0 in the top byte
      function logic [63:0] glyph_bits(input int unsigned entry);
         case (entry)
            1:       return 64'h001F_2444_4424_1F00;
            2:       return 64'h0000_3649_4949_7F00;
            3:       return 64'h0022_4141_4122_1C00;
            4:       return 64'h001C_2241_4141_7F00;
            5:       return 64'h0000_4149_4949_7F00;
            6:       return 64'h0000_4048_4848_7F00;
            7:       return 64'h0027_4541_4122_1C00;
            8:       return 64'h007F_0808_0808_7F00;
            9:       return 64'h0000_0041_7F41_0000;
            10:      return 64'h0000_0040_7E41_0200;
            11:      return 64'h0000_4124_1810_7F00;
            12:      return 64'h0000_0101_0101_7F00;
            13:      return 64'h007F_2010_0820_7F00;
            14:      return 64'h007F_0204_0810_7F00;
            15:      return 64'h001C_2241_4122_1C00;
            16:      return 64'h0000_3048_4848_7F00;
            17:      return 64'h001D_2341_4122_1C00;
            18:      return 64'h0000_314A_4C48_7F00;
            19:      return 64'h0042_4549_4929_1100;
            20:      return 64'h0000_4040_7F40_4000;
            21:      return 64'h007E_0101_0101_7E00;
            22:      return 64'h0078_0402_0304_7800;
            23:      return 64'h007E_0101_1E01_7E00;
            24:      return 64'h0043_2418_2844_4300;
            25:      return 64'h0040_2010_1F20_4000;
            26:      return 64'h0061_5149_4542_4100;
            default: return 64'h0;
         endcase
      endfunction

      // Map a byte to a font entry: blank below '@', fold lower case, blank past 'Z'
      function int unsigned font_entry(input logic [7:0] code);
         logic [7:0] c;
         c = code;
         if (c < CODE_AT) c = CODE_AT;
         if (c >= CODE_LOWER_A) c = c - CASE_SHIFT;
         if (c > CODE_Z) return 0;
         return int'(c - CODE_AT);
      endfunction

      function void queue_frame(input bit last);
         frame_type f;
         for (int i = 0; i < 8; i++) f.cols[63 - 8 * i -: 8] = frame[i];
         f.last = last;
         expected_q.push_back(f);
      endfunction

      // Scroll one character in and queue its eight frames
      function void note_char(input logic [7:0] code, input logic clr);
         logic [63:0] g;
         logic [7:0]  gcol [8];
         g = glyph_bits(font_entry(code));
         for (int i = 0; i < 8; i++) gcol[i] = g[63 - 8 * i -: 8];
         chars_noted++;
         if (clr) begin
            clears_noted++;
            foreach (frame[i]) frame[i] = '0;
         end
         for (int n = 0; n < 8; n++) begin
            if (vertical) begin
               for (int i = 0; i < 8; i++) frame[i] = {frame[i][6:0], gcol[i][7 - n]};
               queue_frame(n == 7);
            end else begin
               queue_frame(n == 7);
               for (int i = 7; i > 0; i--) frame[i] = frame[i - 1];
               frame[0] = gcol[7 - n];
            end
         end
      endfunction

      // Compare one returned frame with the oldest expected one
      function void check_frame(input logic [63:0] cols, input logic last);
         frame_type f;
         frames_checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected frame: cols %h last %b", cols, last);
            return;
         end
         f = expected_q.pop_front();
         if (f.cols !== cols || f.last !== last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("frame mismatch: expected cols %h last %b, got cols %h last %b",
                        f.cols, f.last, cols, last);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_code;
   logic       req_clear_first;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_column_0, rsp_column_1, rsp_column_2, rsp_column_3;
   logic [7:0] rsp_column_4, rsp_column_5, rsp_column_6, rsp_column_7;
   logic       rsp_last_frame;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_scroll_vertical;

   frame_scoreboard board = new();
   bit sender_gaps;
   bit receiver_stalls;
   bit long_hold_req;
   int mode_writes [2];

   led_matrix_text_scroller dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_char_code       (req_char_code),
      .req_clear_first     (req_clear_first),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_column_0        (rsp_column_0),
      .rsp_column_1        (rsp_column_1),
      .rsp_column_2        (rsp_column_2),
      .rsp_column_3        (rsp_column_3),
      .rsp_column_4        (rsp_column_4),
      .rsp_column_5        (rsp_column_5),
      .rsp_column_6        (rsp_column_6),
      .rsp_column_7        (rsp_column_7),
      .rsp_last_frame      (rsp_last_frame),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_scroll_vertical (csr_scroll_vertical)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bound the run
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Check every frame word taken from the block
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_frame({rsp_column_0, rsp_column_1, rsp_column_2, rsp_column_3,
                            rsp_column_4, rsp_column_5, rsp_column_6, rsp_column_7},
                           rsp_last_frame);
   end

   // Drive rsp_ready: random stall bursts, and one long hold on request
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 8'(CODE_AT + 8'd1 + 8'($urandom_range(0, 25)));
         6, 7:             return 8'(CODE_LOWER_A + 8'($urandom_range(0, 25)));
         default:          return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one character word, called at a falling edge; returns at a falling edge
   task automatic push_char(input logic [7:0] code, input logic clr);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_char_code   <= code;
      req_clear_first <= clr;
      do @(posedge clock); while (!req_ready);
      board.note_char(code, clr);
      @(negedge clock);
   endtask

   // Stop offering and wait for every expected frame
   task automatic drain_all();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
   endtask

   // Write the scroll direction register; the block must be idle
   task automatic write_scroll_mode(input bit vert);
      csr_valid           <= 1'b1;
      csr_scroll_vertical <= vert;
      do @(posedge clock); while (!csr_ready);
      board.vertical = vert;
      mode_writes[vert]++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned msg_left;
      int errors;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_char_code       = '0;
      req_clear_first     = 1'b0;
      csr_valid           = 1'b0;
      csr_scroll_vertical = 1'b0;
      sender_gaps         = 1'b1;
      receiver_stalls     = 1'b1;
      long_hold_req       = 1'b0;
      mode_writes         = '{0, 0};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: horizontal scroll over the corner codes
      write_scroll_mode(1'b0);
      foreach (EDGE_CODES[i]) push_char(EDGE_CODES[i], i == 0);
      push_char("M", 1'b1);
      push_char("q", 1'b0);
      drain_all();

      // Directed: vertical scroll
      write_scroll_mode(1'b1);
      push_char("A", 1'b1);
      push_char("W", 1'b0);
      push_char("z", 1'b0);
      push_char(8'hFF, 1'b0);
      push_char("Q", 1'b1);
      push_char(8'h00, 1'b0);
      push_char("X", 1'b0);
      drain_all();

      // Random messages in four phases, alternating the scroll direction
      for (int phase = 0; phase < 4; phase++) begin
         write_scroll_mode(phase[0]);
         if (phase == 3) begin
            sender_gaps     = 1'b0;
            receiver_stalls = 1'b0;
         end
         msg_left = 0;
         for (int k = 0; k < 27; k++) begin
            if (phase == 1 && k == 6) long_hold_req = 1'b1;
            if (phase == 2 && k == 16) drain_all();
            if (msg_left == 0) begin
               msg_left = $urandom_range(1, 8);
               push_char(pick_char(), 1'b1);
            end else begin
               push_char(pick_char(), $urandom_range(0, 9) == 0);
            end
            msg_left--;
         end
         drain_all();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      errors = board.mismatches + board.pending();
      $display("covered %0d characters (%0d with clear), %0d frames checked",
               board.chars_noted, board.clears_noted, board.frames_checked);
      $display("scroll mode writes: %0d horizontal, %0d vertical; %0d frames never came",
               mode_writes[0], mode_writes[1], board.pending());
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
